// ===== rtl/core/hpg_pkg.sv =====
package hpg_pkg;

	localparam int SYM_W           = 8;
	localparam int POS_W           = 3;
	localparam int LEN_W           = 4;
	localparam int CNT_W           = 3;
	localparam int DATA_W          = 16;
	localparam int ACT_W           = 2;
	localparam int STR_CAP         = 8;
	localparam int DEFAULT_MAX_LEN = 8;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_NEXT  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_SWAP_C,
		ST_EMIT,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/heap_permutation_generator.sv =====
// Iterative Heap's-algorithm permutation generator. A load transfer (tuser 0) writes one symbol
// into the string store, a start transfer (tuser 1) clears the swap counters and sends out the
// current string, and each next transfer (tuser 2) swaps one pair and sends out the new string,
// one symbol per output transfer with tlast on the final one; once every permutation has been
// produced a next transfer returns a single done transfer (tuser 1, tlast 1). A next scans the
// counter positions, swaps the pair through the single store read port in states SWAP_A, SWAP_B
// and SWAP_C, then sends the string out through the output register, one symbol per cycle while
// the receiver is ready. Input is not taken while an item is at work; length is written on the
// cfg channel, which is always ready.
module heap_permutation_generator #(
	parameter int MAX_LEN = hpg_pkg::DEFAULT_MAX_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hpg_pkg::DATA_W-1:0]    s_tdata,  // symbol_in [7:0], symbol_index [10:8]
	input  logic [hpg_pkg::ACT_W-1:0]     s_tuser,  // action [1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hpg_pkg::DATA_W-1:0]    m_tdata,  // symbol_out [7:0], position [10:8]
	output logic                          m_tlast,
	output logic [0:0]                    m_tuser,  // done_res [0]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hpg_pkg::LEN_W-1:0]     cfg_data
);
	import hpg_pkg::*;

	localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LenCap = (MAX_LEN < STR_CAP) ? MAX_LEN : STR_CAP;
	localparam int PAD_W  = DATA_W - SYM_W - POS_W;

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  len_eff;
	logic              finished_q;
	logic [LEN_W-1:0]  x_q;
	logic [POS_W-1:0]  k_q;
	logic [SYM_W-1:0]  tmp_q;
	logic [SYM_W-1:0]  store_q [MAX_LEN];
	logic [CNT_W-1:0]  cnt_q [MAX_LEN];
	logic [CNT_W-1:0]  cnt_x;
	logic [CNT_W-1:0]  y;
	logic              s_fire;
	action_t           act;
	logic [SYM_W-1:0]  sym_in;
	logic [POS_W-1:0]  idx_in;
	logic              out_free;
	logic              k_last;

	logic [AW-1:0]     rd_addr;
	logic [SYM_W-1:0]  rd_data;
	logic              st_we;
	logic [AW-1:0]     st_waddr;
	logic [SYM_W-1:0]  st_wdata;
	logic              out_ld;

	logic              m_tvalid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_last_q;
	logic              out_done_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_fire    = s_tvalid && s_tready;
	assign act       = action_t'(s_tuser);
	assign sym_in    = s_tdata[SYM_W-1:0];
	assign idx_in    = s_tdata[SYM_W +: POS_W];
	assign out_free  = !m_tvalid_q || m_tready;

	assign len_eff = (length_q == '0) ? LEN_W'(1) :
		((length_q > LEN_W'(LenCap)) ? LEN_W'(LenCap) : length_q);
	assign cnt_x   = cnt_q[AW'(x_q)];
	assign y       = x_q[0] ? cnt_x : '0;
	assign k_last  = (LEN_W'(k_q) + LEN_W'(1)) == len_eff;
	assign rd_data = store_q[rd_addr];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					unique case (act)
						ACT_START: state_d = ST_EMIT;
						ACT_NEXT:  state_d = finished_q ? ST_DONE : ST_SCAN;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				priority if (x_q >= len_eff) begin
					state_d = ST_DONE;
				end else if (LEN_W'(cnt_x) < x_q) begin
					state_d = ST_SWAP_A;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SWAP_A: state_d = ST_SWAP_B;
			ST_SWAP_B: state_d = ST_SWAP_C;
			ST_SWAP_C: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free && k_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		rd_addr  = AW'(k_q);
		st_we    = 1'b0;
		st_waddr = AW'(idx_in);
		st_wdata = sym_in;
		out_ld   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				st_we = s_fire && (act == ACT_LOAD) && (int'(idx_in) < MAX_LEN);
			end
			ST_SWAP_A: rd_addr = AW'(x_q);
			ST_SWAP_B: begin
				rd_addr  = AW'(y);
				st_we    = 1'b1;
				st_waddr = AW'(x_q);
				st_wdata = rd_data;
			end
			ST_SWAP_C: begin
				st_we    = 1'b1;
				st_waddr = AW'(y);
				st_wdata = tmp_q;
			end
			ST_EMIT: out_ld = out_free;
			ST_DONE: out_ld = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_q[st_waddr] <= st_wdata;
		end
		if (state_q == ST_SWAP_A) begin
			tmp_q <= rd_data;
		end
		if (out_ld) begin
			if (state_q == ST_DONE) begin
				out_sym_q  <= '0;
				out_pos_q  <= '0;
				out_last_q <= 1'b1;
				out_done_q <= 1'b1;
			end else begin
				out_sym_q  <= rd_data;
				out_pos_q  <= k_q;
				out_last_q <= k_last;
				out_done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			length_q   <= LEN_RESET;
			finished_q <= 1'b0;
			x_q        <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < MAX_LEN; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				length_q <= cfg_data;
			end
			if (out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					x_q <= LEN_W'(1);
					if (s_fire && act == ACT_START) begin
						finished_q <= 1'b0;
						for (int i = 0; i < MAX_LEN; i++) begin
							cnt_q[i] <= '0;
						end
					end
				end
				ST_SCAN: begin
					priority if (x_q >= len_eff) begin
						finished_q <= 1'b1;
					end else if (LEN_W'(cnt_x) >= x_q) begin
						cnt_q[AW'(x_q)] <= '0;
						x_q             <= x_q + LEN_W'(1);
					end else begin
						// qualifying position, swap follows
					end
				end
				ST_SWAP_C: begin
					cnt_q[AW'(x_q)] <= cnt_x + CNT_W'(1);
					k_q             <= '0;
				end
				ST_EMIT: begin
					if (out_free) begin
						k_q <= k_q + POS_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_pos_q, out_sym_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

`ifndef SYNTH
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("done transfer without tlast or with data");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> (x_q >= LEN_W'(1)) && (x_q <= len_eff))
		else $error("scan position out of range");

	a_swap_counter: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWAP_C |-> LEN_W'(cnt_x) < x_q)
		else $error("swap with exhausted counter");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_DONE) && out_free |=> m_tvalid)
		else $error("output register not loaded");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && act == ACT_NEXT |=> !s_tready)
		else $error("next item finished in one cycle");
`endif

endmodule

// ===== verif/heap_permutation_generator_checker.sv =====
`timescale 1ns / 100ps

module heap_permutation_generator_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [hpg_pkg::DATA_W-1:0] s_tdata,  // symbol_in [7:0], symbol_index [10:8]
	input  logic [hpg_pkg::ACT_W-1:0]  s_tuser,  // action [1:0]
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [hpg_pkg::DATA_W-1:0] m_tdata,  // symbol_out [7:0], position [10:8]
	input  logic                       m_tlast,
	input  logic [0:0]                 m_tuser,  // done_res [0]
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [hpg_pkg::LEN_W-1:0]  cfg_data,
	output int                         error_count,
	output int                         awaiting
);
	import hpg_pkg::*;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic [POS_W-1:0] pos;
		logic             last;
		logic             done;
	} emitted_t;

	logic [SYM_W-1:0] string_mem [STR_CAP];
	logic [CNT_W-1:0] swap_cnt [STR_CAP];
	logic             exhausted;
	logic [LEN_W-1:0] length_reg;
	emitted_t         awaited_q [$];
	int               errors_seen = 0;

	function automatic int active_len();
		int n;
		n = length_reg;
		if (n < 1) n = 1;
		if (n > STR_CAP) n = STR_CAP;
		return n;
	endfunction

	task automatic queue_string();
		int n;
		emitted_t e;
		n = active_len();
		for (int k = 0; k < n; k++) begin
			e.sym  = string_mem[k];
			e.pos  = POS_W'(k);
			e.last = (k == n - 1);
			e.done = 1'b0;
			awaited_q.push_back(e);
		end
	endtask

	task automatic queue_done();
		emitted_t e;
		e.sym  = '0;
		e.pos  = '0;
		e.last = 1'b1;
		e.done = 1'b1;
		awaited_q.push_back(e);
	endtask

	// one step of iterative heap permutation
	task automatic step_heap(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
	                         input logic [POS_W-1:0] idx);
		int n;
		int y;
		logic [SYM_W-1:0] t;
		case (act)
			ACT_LOAD: begin
				string_mem[idx] = sym;
			end
			ACT_START: begin
				for (int k = 0; k < STR_CAP; k++) swap_cnt[k] = '0;
				exhausted = 1'b0;
				queue_string();
			end
			ACT_NEXT: begin
				n = active_len();
				if (exhausted) begin
					queue_done();
				end else begin
					for (int x = 1; x < n; x++) begin
						if (swap_cnt[x] < x) begin
							y = x[0] ? int'(swap_cnt[x]) : 0;
							t = string_mem[y];
							string_mem[y] = string_mem[x];
							string_mem[x] = t;
							swap_cnt[x] = swap_cnt[x] + 1'b1;
							queue_string();
							return;
						end
						swap_cnt[x] = '0;
					end
					exhausted = 1'b1;
					queue_done();
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_symbol(input emitted_t got);
		emitted_t want;
		if (awaited_q.size() == 0) begin
			errors_seen++;
			if (errors_seen <= 10)
				$display("unexpected output transfer: sym %02h pos %0d last %0b done %0b",
				         got.sym, got.pos, got.last, got.done);
		end else begin
			want = awaited_q.pop_front();
			if (got.sym !== want.sym || got.pos !== want.pos || got.last !== want.last ||
			    got.done !== want.done) begin
				errors_seen++;
				if (errors_seen <= 10)
					$display({"mismatch: expected sym %02h pos %0d last %0b done %0b, ",
					          "got sym %02h pos %0d last %0b done %0b"},
					         want.sym, want.pos, want.last, want.done,
					         got.sym, got.pos, got.last, got.done);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STR_CAP; k++) begin
				string_mem[k] = '0;
				swap_cnt[k]   = '0;
			end
			exhausted  = 1'b0;
			length_reg = LEN_RESET;
			awaited_q.delete();
			error_count <= errors_seen;
			awaiting    <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_symbol({m_tdata[SYM_W-1:0], m_tdata[SYM_W+POS_W-1:SYM_W],
				              m_tlast, m_tuser[0]});
			if (cfg_valid && cfg_ready)
				length_reg = cfg_data;
			if (s_tvalid && s_tready)
				step_heap(s_tuser, s_tdata[SYM_W-1:0], s_tdata[SYM_W+POS_W-1:SYM_W]);
			error_count <= errors_seen;
			awaiting    <= awaited_q.size();
		end
	end

endmodule

// ===== verif/heap_permutation_generator_tb.sv =====
`timescale 1ns / 100ps

module heap_permutation_generator_tb;
	import hpg_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 300;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata   = '0;
	logic [ACT_W-1:0]  s_tuser   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic [0:0]        m_tuser;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LEN_W-1:0]  cfg_data  = '0;

	int                error_count;
	int                awaiting;
	int                quiet_cycles = 0;
	logic              squeeze_req    = 1'b0;
	logic              squeeze_served = 1'b0;
	logic [LEN_W-1:0]  len_plan [12];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	heap_permutation_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	heap_permutation_generator_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.error_count (error_count),
		.awaiting    (awaiting)
	);

	task automatic push_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
	                         input logic [POS_W-1:0] idx);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(DATA_W-SYM_W-POS_W){1'b0}}, idx, sym};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_input(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// let every expected transfer arrive, then cover a trailing load
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("heap_permutation_generator_tb: done, errors");
			$finish;
		end
	end

	// receiver side stalls
	initial begin : rx_side
		int mode;
		int seg_len;
		wait (arst_n);
		forever begin
			if (squeeze_req && !squeeze_served) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				squeeze_served = 1'b1;
			end else begin
				mode    = $urandom_range(0, 3);
				seg_len = $urandom_range(10, 60);
				for (int k = 0; k < seg_len && !(squeeze_req && !squeeze_served); k++) begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int phase;
		int n_eff;
		int n_items;
		int burst;
		int gap;
		int pick;
		logic [LEN_W-1:0] len_val;
		logic [ACT_W-1:0] act;

		len_plan = '{4'd1, 4'd2, 4'd4, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd4, 4'd8, 4'd9, 4'd3};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole store first
		push_item(ACT_LOAD, 8'h00, 3'd0);
		push_item(ACT_LOAD, 8'hff, 3'd1);
		push_item(ACT_LOAD, 8'ha5, 3'd2);
		push_item(ACT_LOAD, 8'h5a, 3'd3);
		push_item(ACT_LOAD, 8'h01, 3'd4);
		push_item(ACT_LOAD, 8'h80, 3'd5);
		push_item(ACT_LOAD, 8'h7e, 3'd6);
		push_item(ACT_LOAD, 8'h3c, 3'd7);
		// next with no start, unused code, then run length three to exhaustion and past it
		push_item(ACT_NEXT, 8'h00, 3'd0);
		push_item(ACT_UNUSED, 8'hff, 3'd7);
		push_item(ACT_START, SYM_W'($urandom), POS_W'($urandom));
		repeat (7) push_item(ACT_NEXT, SYM_W'($urandom), POS_W'($urandom));
		settle();
		write_length(4'd1);
		push_item(ACT_START, 8'h00, 3'd0);
		push_item(ACT_NEXT, 8'h00, 3'd0);
		push_item(ACT_NEXT, 8'hff, 3'd7);
		settle();

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			len_val = (phase < 12) ? len_plan[phase] : LEN_W'($urandom_range(0, 15));
			write_length(len_val);
			n_eff = (len_val == 0) ? 1 : ((len_val > STR_CAP) ? STR_CAP : int'(len_val));
			if (n_eff <= 3)
				n_items = $urandom_range(8, 14);
			else if (n_eff == 4)
				n_items = $urandom_range(36, 46);
			else
				n_items = $urandom_range(8, 16);
			if (phase == 2)
				squeeze_req = 1'b1;
			if ($urandom_range(0, 7) != 0) begin
				push_item(ACT_START, SYM_W'($urandom), POS_W'($urandom));
				sent++;
			end
			burst = $urandom_range(1, 12);
			for (int k = 0; k < n_items; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 85)
					act = ACT_NEXT;
				else if (pick < 88)
					act = ACT_START;
				else if (pick < 96)
					act = ACT_LOAD;
				else
					act = ACT_UNUSED;
				push_item(act, SYM_W'($urandom), POS_W'($urandom));
				if (act != ACT_UNUSED)
					sent++;
				burst--;
				if (burst == 0) begin
					if ($urandom_range(0, 3) == 0)
						gap = 0;
					else
						gap = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 5);
					if (gap != 0)
						pause_input(gap);
					burst = $urandom_range(1, 12);
				end
			end
			settle();
			phase++;
		end

		if (error_count == 0 && awaiting == 0)
			$display("heap_permutation_generator_tb: done, clean");
		else
			$display("heap_permutation_generator_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/hpg_pkg.sv
rtl/core/heap_permutation_generator.sv
verif/heap_permutation_generator_checker.sv
verif/heap_permutation_generator_tb.sv
